// ===== rtl/aslot_pkg.sv =====
// aslot_pkg: shared widths and operation codes for the aged slot table.
// No dependencies; used by aged_slot_table_oldest_evict.
`timescale 1ns / 1ps
`default_nettype none

package aslot_pkg;

  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int AGE_W    = 32;

  typedef logic [AGE_W-1:0] age_t;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/aged_slot_table_oldest_evict.sv =====
// aged_slot_table_oldest_evict: slot table with per-slot ages and oldest-entry replacement.
// The result is registered after the scan; a zero handle skips the scan and is rejected.
// Takes a new transaction only when idle, after the last result; a single read-modify-write pass
// over the handle and age memories, one slot per cycle through one shared increment and compare.
// Reset: synchronous active-low rst_n clears every slot valid bit and the occupied count at once.
// Depends on aslot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aged_slot_table_oldest_evict #(
  parameter int SLOTS       = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [aslot_pkg::HANDLE_W-1:0] in_handle,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_ok,
  output logic [aslot_pkg::SLOT_W-1:0]       out_slot,
  output logic                               out_evicted,
  output logic [aslot_pkg::HANDLE_W-1:0]     out_evicted_handle,
  output logic [aslot_pkg::COUNT_W-1:0]      out_count
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  typedef logic [HANDLE_BITS-1:0] hnd_t;

  logic [1:0]          state_r, state_nxt;
  logic                func_r, func_nxt;
  hnd_t                h_r, h_nxt;
  logic                rej_r, rej_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pv_r, pv_nxt;
  logic [IW-1:0]       pidx_r, pidx_nxt;
  logic                hit_r, hit_nxt;
  logic [IW-1:0]       where_r, where_nxt;
  logic [IW-1:0]       best_r, best_nxt;
  aslot_pkg::age_t     best_age_r, best_age_nxt;
  hnd_t                best_hand_r, best_hand_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [SLOTS-1:0]    vld_r, vld_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [IW-1:0]       out_slot_r, out_slot_nxt;
  logic                out_ev_r, out_ev_nxt;
  hnd_t                out_evh_r, out_evh_nxt;
  logic [CW-1:0]       out_cnt_r, out_cnt_nxt;

  hnd_t                hand_mem [SLOTS];
  aslot_pkg::age_t     age_mem  [SLOTS];
  hnd_t                rd_hand_r;
  aslot_pkg::age_t     rd_age_r;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_hand_en, wr_age_en;
  logic [IW-1:0]       wr_addr;
  hnd_t                wr_hand;
  aslot_pkg::age_t     wr_age;

  logic                in_fire;
  logic                out_free;
  hnd_t                h_in;
  aslot_pkg::age_t     age_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign h_in      = HANDLE_BITS'(in_handle);
  assign age_inc   = rd_age_r + aslot_pkg::age_t'(1);
  assign rd_addr   = cnt_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    h_nxt         = h_r;
    rej_nxt       = rej_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    hit_nxt       = hit_r;
    where_nxt     = where_r;
    best_nxt      = best_r;
    best_age_nxt  = best_age_r;
    best_hand_nxt = best_hand_r;
    occ_nxt       = occ_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_ev_nxt    = out_ev_r;
    out_evh_nxt   = out_evh_r;
    out_cnt_nxt   = out_cnt_r;
    rd_en         = 1'b0;
    wr_hand_en    = 1'b0;
    wr_age_en     = 1'b0;
    wr_addr       = pidx_r;
    wr_hand       = h_r;
    wr_age        = age_inc;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt     = in_func;
          h_nxt        = h_in;
          rej_nxt      = (h_in == '0);
          cnt_nxt      = '0;
          hit_nxt      = 1'b0;
          where_nxt    = '0;
          best_nxt     = '0;
          best_age_nxt = '0;
          state_nxt    = (h_in == '0) ? ST_FINAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CW'(SLOTS)) begin
          state_nxt = ST_FINAL;
        end else begin
          rd_en    = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = cnt_r[IW-1:0];
        end
        if (pv_r) begin
          if (func_r == aslot_pkg::FUNC_ADD) begin
            if (!vld_r[pidx_r] && !hit_r) begin
              wr_hand_en      = 1'b1;
              wr_age_en       = 1'b1;
              wr_age          = '0;
              vld_nxt[pidx_r] = 1'b1;
              hit_nxt         = 1'b1;
              where_nxt       = pidx_r;
            end else if (vld_r[pidx_r]) begin
              wr_age_en = 1'b1;
              if ((pidx_r == '0) || (age_inc > best_age_r)) begin
                best_nxt      = pidx_r;
                best_age_nxt  = age_inc;
                best_hand_nxt = rd_hand_r;
              end
            end
          end else if (vld_r[pidx_r] && (rd_hand_r == h_r) && !hit_r) begin
            hit_nxt   = 1'b1;
            where_nxt = pidx_r;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_slot_nxt  = '0;
          out_ev_nxt    = 1'b0;
          out_evh_nxt   = '0;
          state_nxt     = ST_IDLE;
          priority if (rej_r) begin
            out_cnt_nxt = occ_r;
          end else if (func_r == aslot_pkg::FUNC_ADD) begin
            out_ok_nxt = 1'b1;
            if (hit_r) begin
              occ_nxt      = occ_r + CW'(1);
              out_slot_nxt = where_r;
              out_cnt_nxt  = occ_r + CW'(1);
            end else begin
              wr_hand_en   = 1'b1;
              wr_age_en    = 1'b1;
              wr_addr      = best_r;
              wr_age       = '0;
              out_slot_nxt = best_r;
              out_ev_nxt   = 1'b1;
              out_evh_nxt  = best_hand_r;
              out_cnt_nxt  = occ_r;
            end
          end else if (hit_r) begin
            vld_nxt[where_r] = 1'b0;
            occ_nxt          = occ_r - CW'(1);
            out_ok_nxt       = 1'b1;
            out_slot_nxt     = where_r;
            out_cnt_nxt      = occ_r - CW'(1);
          end else begin
            out_cnt_nxt = occ_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hand_r <= hand_mem[rd_addr];
      rd_age_r  <= age_mem[rd_addr];
    end
    if (wr_hand_en) begin
      hand_mem[wr_addr] <= wr_hand;
    end
    if (wr_age_en) begin
      age_mem[wr_addr] <= wr_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pv_r        <= 1'b0;
      occ_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      occ_r       <= occ_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    h_r         <= h_nxt;
    rej_r       <= rej_nxt;
    cnt_r       <= cnt_nxt;
    pidx_r      <= pidx_nxt;
    hit_r       <= hit_nxt;
    where_r     <= where_nxt;
    best_r      <= best_nxt;
    best_age_r  <= best_age_nxt;
    best_hand_r <= best_hand_nxt;
    out_ok_r    <= out_ok_nxt;
    out_slot_r  <= out_slot_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evh_r   <= out_evh_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_slot           = aslot_pkg::SLOT_W'(out_slot_r);
  assign out_evicted        = out_ev_r;
  assign out_evicted_handle = aslot_pkg::HANDLE_W'(out_evh_r);
  assign out_count          = aslot_pkg::COUNT_W'(out_cnt_r);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(SLOTS))
    else $error("occupied count above slot count");

  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(vld_r) == int'(occ_r)))
    else $error("occupied count disagrees with valid bits");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> ((out_slot_r == '0) && !out_ev_r && (out_evh_r == '0)))
    else $error("failed transaction carries slot or eviction data");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

endmodule

`default_nettype wire
